// ===== hdl/insertion_sorter_assert.svh =====
// assertion macros for the sorter checks
`ifndef INSERTION_SORTER_ASSERT_SVH
`define INSERTION_SORTER_ASSERT_SVH

// condition that must hold at every clock edge outside reset
`define INSORT_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// trigger in one cycle implies the condition in the next cycle
`define INSORT_ASSERT_NEXT(lbl, trig, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (trig) |=> (cond)) \
    else $error(msg);

`endif

// ===== hdl/insort_pkg.sv =====
package insort_pkg;

  // default configuration
  localparam int unsigned NDefault         = 16;
  localparam int unsigned DataWidthDefault = 32;

  // per-cycle command that every cell of the chain sees
  typedef struct packed {
    logic insert;  // place the incoming value, shift larger ones right
    logic shift;   // move every value one cell toward the output
  } cell_ctrl_t;

endpackage

// ===== hdl/insort_in_if.sv =====
interface insort_in_if #(
  parameter int unsigned DATA_WIDTH = insort_pkg::DataWidthDefault
);
  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] in_value;
  logic                         in_last;

  modport source (output valid, output in_value, output in_last, input ready);
  modport sink (input valid, input in_value, input in_last, output ready);
endinterface

// ===== hdl/insort_out_if.sv =====
interface insort_out_if #(
  parameter int unsigned DATA_WIDTH = insort_pkg::DataWidthDefault
);
  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] out_value;
  logic                         out_last;
  logic                         out_overflow;

  modport source (output valid, output out_value, output out_last, output out_overflow,
                  input ready);
  modport sink (input valid, input out_value, input out_last, input out_overflow,
                output ready);
endinterface

// ===== hdl/insort_cell.sv =====
module insort_cell #(
  parameter int unsigned DATA_WIDTH = insort_pkg::DataWidthDefault
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  insort_pkg::cell_ctrl_t       ctrl_i,
  input  logic signed [DATA_WIDTH-1:0] new_value_i,
  input  logic signed [DATA_WIDTH-1:0] prev_value_i,
  input  logic                         prev_valid_i,
  input  logic                         prev_gt_i,
  input  logic signed [DATA_WIDTH-1:0] next_value_i,
  input  logic                         next_valid_i,
  output logic signed [DATA_WIDTH-1:0] value_o,
  output logic                         valid_o,
  output logic                         gt_o
);

  logic signed [DATA_WIDTH-1:0] value_q, value_d;
  logic                         valid_q, valid_d;

  // an empty cell counts as holding a value above everything
  assign gt_o = !valid_q || (value_q > new_value_i);

  // insert from the left neighbor or take the new item, shift from the right
  always_comb begin
    value_d = value_q;
    valid_d = valid_q;
    if (ctrl_i.insert && gt_o) begin
      if (prev_gt_i) begin
        value_d = prev_value_i;
        valid_d = prev_valid_i;
      end else begin
        value_d = new_value_i;
        valid_d = 1'b1;
      end
    end else if (ctrl_i.shift) begin
      value_d = next_value_i;
      valid_d = next_valid_i;
    end
  end

  // occupancy flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // held value
  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  assign value_o = value_q;
  assign valid_o = valid_q;

endmodule

// ===== hdl/insertion_sorter.sv =====
// Insertion sorter for sets of signed values.
// in_i carries one value per item, with in_last on the final value of a set.
// out_o returns the set in ascending order, out_last on the final value and
// out_overflow on every value of a set that had more than N values.
// A chain of N compare cells keeps the set sorted: every accepted item that
// fits is placed in its cell in the cycle it is accepted, larger values move
// one cell right. Input takes one item per cycle while a set is collected.
// Values beyond N are dropped and mark the set as overflowed.
// After the last item the chain shifts toward cell 0, which drives out_o
// directly: the first result is shown the cycle after in_last is accepted,
// then one result per cycle while out_o is ready.
// in_i.ready is low while a set drains; a stall on out_o freezes the chain
// and holds the shown result. After the final result the next set may start
// in the following cycle.
// Reset empties all cells and clears the overflow flag; no clearing pass.
module insertion_sorter #(
  parameter int unsigned N          = insort_pkg::NDefault,
  parameter int unsigned DATA_WIDTH = insort_pkg::DataWidthDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  insort_in_if.sink   in_i,
  insort_out_if.source out_o
);

  typedef enum logic {
    ST_FILL,
    ST_DRAIN
  } state_e;

  state_e                       state_q;
  logic                         overflow_q;
  insort_pkg::cell_ctrl_t       ctrl;
  logic signed [DATA_WIDTH-1:0] cell_value [N];
  logic [N-1:0]                 cell_valid;
  logic [N-1:0]                 cell_gt;
  logic                         in_acc;
  logic                         out_acc;
  logic                         full;

  // handshakes
  assign in_i.ready = (state_q == ST_FILL);
  assign in_acc     = in_i.valid && in_i.ready;
  assign out_acc    = out_o.valid && out_o.ready;
  assign full       = cell_valid[N-1];

  assign ctrl.insert = in_acc && !full;
  assign ctrl.shift  = out_acc;

  // chain of compare cells
  for (genvar i = 0; i < N; i++) begin : g_cell
    logic signed [DATA_WIDTH-1:0] prev_value;
    logic                         prev_valid;
    logic                         prev_gt;
    logic signed [DATA_WIDTH-1:0] next_value;
    logic                         next_valid;

    if (i == 0) begin : g_head
      assign prev_value = in_i.in_value;
      assign prev_valid = 1'b1;
      assign prev_gt    = 1'b0;
    end else begin : g_body
      assign prev_value = cell_value[i-1];
      assign prev_valid = cell_valid[i-1];
      assign prev_gt    = cell_gt[i-1];
    end

    if (i == N - 1) begin : g_tail
      assign next_value = cell_value[i];
      assign next_valid = 1'b0;
    end else begin : g_mid
      assign next_value = cell_value[i+1];
      assign next_valid = cell_valid[i+1];
    end

    insort_cell #(
      .DATA_WIDTH(DATA_WIDTH)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctrl_i      (ctrl),
      .new_value_i (in_i.in_value),
      .prev_value_i(prev_value),
      .prev_valid_i(prev_valid),
      .prev_gt_i   (prev_gt),
      .next_value_i(next_value),
      .next_valid_i(next_valid),
      .value_o     (cell_value[i]),
      .valid_o     (cell_valid[i]),
      .gt_o        (cell_gt[i])
    );
  end

  // result taken from the head cell
  assign out_o.valid        = (state_q == ST_DRAIN);
  assign out_o.out_value    = cell_value[0];
  assign out_o.out_last     = !cell_valid[1];
  assign out_o.out_overflow = overflow_q;

  // collect and drain sequencing
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_FILL;
      overflow_q <= 1'b0;
    end else begin
      unique case (state_q)
        ST_FILL: begin
          if (in_acc) begin
            if (full) begin
              overflow_q <= 1'b1;
            end
            if (in_i.in_last) begin
              state_q <= ST_DRAIN;
            end
          end
        end
        ST_DRAIN: begin
          if (out_acc && !cell_valid[1]) begin
            state_q    <= ST_FILL;
            overflow_q <= 1'b0;
          end
        end
        default: begin
          state_q <= ST_FILL;
        end
      endcase
    end
  end

  // checks
  `include "insertion_sorter_assert.svh"

  `INSORT_ASSERT_ALWAYS(a_drain_has_head, (state_q != ST_DRAIN) || cell_valid[0], "drain with empty head cell")
  `INSORT_ASSERT_ALWAYS(a_cells_packed, $onehot({1'b0, cell_valid} + {{N{1'b0}}, 1'b1}), "occupied cells not packed from the head")
  `INSORT_ASSERT_ALWAYS(a_overflow_full, !overflow_q || full || (state_q == ST_DRAIN), "overflow flagged while collecting on a chain that is not full")
  `INSORT_ASSERT_NEXT(a_empty_after_set, out_acc && out_o.out_last, (cell_valid == '0) && !overflow_q && in_i.ready, "chain not cleared after final result")

endmodule

// ===== bench/insertion_sorter_tb.sv =====
module insertion_sorter_tb;

  localparam int unsigned N      = insort_pkg::NDefault;
  localparam int unsigned DW     = insort_pkg::DataWidthDefault;
  localparam int unsigned MaxGap = 13;
  localparam int unsigned RandomItems = 320;

  localparam logic signed [DW-1:0] MaxVal = {1'b0, {(DW-1){1'b1}}};
  localparam logic signed [DW-1:0] MinVal = {1'b1, {(DW-1){1'b0}}};

  typedef struct packed {
    logic signed [DW-1:0] value;
    logic                 last;
  } sort_item_t;

  typedef struct packed {
    logic signed [DW-1:0] value;
    logic                 last;
    logic                 overflow;
  } sorted_value_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  insort_in_if #(.DATA_WIDTH(DW)) in_if ();
  insort_out_if #(.DATA_WIDTH(DW)) out_if ();

  insertion_sorter #(
    .N         (N),
    .DATA_WIDTH(DW)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if)
  );

  // items waiting to be sent and sorted values waiting to come out
  sort_item_t    items_to_send[$];
  sorted_value_t sorted_due[$];

  // running copy of the set being collected
  logic signed [DW-1:0] held_vals[N];
  int                   held_cnt  = 0;
  logic                 held_ovf  = 1'b0;

  int errors         = 0;
  int sets_sorted    = 0;
  int sets_overflow  = 0;
  int values_checked = 0;
  int random_items   = 0;

  int unsigned   send_gap;
  int unsigned   recv_gap;
  int unsigned   draw_gap;
  bit            send_idles = 1'b1;
  bit            recv_idles = 1'b1;
  sort_item_t    next_item;
  sorted_value_t got;
  sorted_value_t want;

  // clock
  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // place one value in the held set; on the last item emit the set in order
  task automatic sort_into_set(input logic signed [DW-1:0] v, input logic last);
    int            pos;
    sorted_value_t r;
    if (held_cnt < N) begin
      pos = held_cnt;
      while (pos > 0 && held_vals[pos-1] > v) begin
        held_vals[pos] = held_vals[pos-1];
        pos--;
      end
      held_vals[pos] = v;
      held_cnt++;
    end else begin
      held_ovf = 1'b1;
    end
    if (last) begin
      sets_sorted++;
      if (held_ovf) sets_overflow++;
      for (int i = 0; i < held_cnt; i++) begin
        r.value    = held_vals[i];
        r.last     = (i == held_cnt - 1);
        r.overflow = held_ovf;
        sorted_due.push_back(r);
      end
      held_cnt = 0;
      held_ovf = 1'b0;
    end
  endtask

  task automatic queue_item(input logic signed [DW-1:0] v, input logic last);
    sort_item_t it;
    it.value = v;
    it.last  = last;
    items_to_send.push_back(it);
  endtask

  // extremes, a narrow band for duplicates, or any pattern
  function automatic logic signed [DW-1:0] pick_value();
    logic signed [DW-1:0] v;
    case ($urandom_range(0, 9))
      0: v = MaxVal;
      1: v = MinVal;
      2, 3, 4: begin
        v = $urandom_range(0, 8);
        v = v - 4;
      end
      default: v = $urandom();
    endcase
    return v;
  endfunction

  // input driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_if.valid    <= 1'b0;
      in_if.in_value <= '0;
      in_if.in_last  <= 1'b0;
      send_gap       <= 0;
    end else begin
      if (in_if.valid && in_if.ready) sort_into_set(in_if.in_value, in_if.in_last);
      if (!in_if.valid || in_if.ready) begin
        if (send_gap != 0) begin
          in_if.valid <= 1'b0;
          send_gap    <= send_gap - 1;
        end else if (items_to_send.size() != 0) begin
          next_item = items_to_send.pop_front();
          in_if.valid    <= 1'b1;
          in_if.in_value <= next_item.value;
          in_if.in_last  <= next_item.last;
          if ($urandom_range(0, 29) == 0) send_idles = !send_idles;
          send_gap <= send_idles ? $urandom_range(0, MaxGap) : 0;
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // output monitor and random stalls
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
      recv_gap     <= 0;
    end else if (out_if.valid && out_if.ready) begin
      got.value    = out_if.out_value;
      got.last     = out_if.out_last;
      got.overflow = out_if.out_overflow;
      if (sorted_due.size() == 0) begin
        errors++;
        $display("%0t: unexpected result: value %0d last %0b overflow %0b",
                 $time, got.value, got.last, got.overflow);
      end else begin
        want = sorted_due.pop_front();
        values_checked++;
        if (got !== want) begin
          errors++;
          $display("%0t: mismatch: expected value %0d last %0b overflow %0b, got value %0d last %0b overflow %0b",
                   $time, want.value, want.last, want.overflow,
                   got.value, got.last, got.overflow);
        end
      end
      if ($urandom_range(0, 29) == 0) recv_idles = !recv_idles;
      draw_gap = recv_idles ? $urandom_range(0, MaxGap) : 0;
      out_if.ready <= (draw_gap == 0);
      recv_gap     <= (draw_gap == 0) ? 0 : draw_gap - 1;
    end else if (!out_if.ready) begin
      if (recv_gap == 0) out_if.ready <= 1'b1;
      else recv_gap <= recv_gap - 1;
    end
  end

  // stimulus and end of run
  initial begin
    int set_len;
    int kind;
    rst_ni         = 1'b0;
    in_if.valid    = 1'b0;
    in_if.in_value = '0;
    in_if.in_last  = 1'b0;
    out_if.ready   = 1'b0;

    // single-value sets at both extremes
    queue_item(MaxVal, 1'b1);
    queue_item(MinVal, 1'b1);
    // extremes and the values around zero in one set
    queue_item(MaxVal, 1'b0);
    queue_item(MinVal, 1'b0);
    queue_item(-1, 1'b0);
    queue_item(0, 1'b0);
    queue_item(1, 1'b1);
    // one value too many: the marked item is dropped, duplicates included
    for (int i = 0; i <= N; i++) begin
      if (i == 2) queue_item(MaxVal, 1'b0);
      else if (i == 9) queue_item(MinVal, 1'b0);
      else if (i % 3 == 0) queue_item(5, i == N);
      else queue_item(i * 9973 - 80000, i == N);
    end

    // random sets, mostly short, some full, a few overflowing
    while (random_items < RandomItems) begin
      kind = $urandom_range(0, 19);
      if (kind < 2) set_len = 1;
      else if (kind < 15) set_len = $urandom_range(2, 8);
      else if (kind < 18) set_len = $urandom_range(9, N);
      else if (kind == 18) set_len = N;
      else set_len = $urandom_range(N + 1, N + 6);
      for (int k = 0; k < set_len; k++) queue_item(pick_value(), k == set_len - 1);
      random_items += set_len;
    end

    repeat (10) @(posedge clk_i);
    @(negedge clk_i) rst_ni = 1'b1;

    while (items_to_send.size() != 0 || in_if.valid || sorted_due.size() != 0)
      @(posedge clk_i);
    repeat (2 * N) @(posedge clk_i);

    $display("sorted %0d sets (%0d of them overflowed), %0d values checked",
             sets_sorted, sets_overflow, values_checked);
    if (errors == 0 && sorted_due.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // watchdog
  initial begin
    #2000000;
    $display("TEST FAILED");
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+hdl
hdl/insort_pkg.sv
hdl/insort_in_if.sv
hdl/insort_out_if.sv
hdl/insort_cell.sv
hdl/insertion_sorter.sv
bench/insertion_sorter_tb.sv
